[src/nop_pkg.sv]
// Shared types, constants and the arctangent table for the oscillation
// probability pipeline. No dependencies.
package nop_pkg;

  localparam int CORDIC_STAGES = 28;
  localparam int COEF_W = 48;
  localparam int ENERGY_W = 24;
  localparam int PHASE_W = 33;
  localparam int WEIGHT_W = 32;
  localparam int XY_W = 36;
  localparam int Z_W = 33;
  localparam int ACC_W = 40;
  localparam int DIV_STAGES = COEF_W;
  localparam int LANES = 6;
  localparam int IDX_W = $clog2(CORDIC_STAGES + 1);

  localparam logic [31:0] CORDIC_GAIN = 32'h9B74EDA8;

  typedef enum logic [2:0] {
    REG_COEF_12   = 3'd0,
    REG_COEF_13   = 3'd1,
    REG_COEF_23   = 3'd2,
    REG_WEIGHT_12 = 3'd3,
    REG_WEIGHT_13 = 3'd4,
    REG_WEIGHT_23 = 3'd5,
    REG_CP_WEIGHT = 3'd6,
    REG_APPEAR    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [2:0][COEF_W-1:0]   coef;
    logic [2:0][WEIGHT_W-1:0] weight;
    logic [WEIGHT_W-1:0]      cp;
    logic                     app;
  } cfg_t;

  // one word in flight through the divider row
  typedef struct packed {
    logic                       valid;
    logic [ENERGY_W-1:0]        energy;
    logic [2:0][ENERGY_W-1:0]   rem;
    logic [2:0][PHASE_W-1:0]    quo;
  } div_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   flip;
  } lane_t;

  // lanes 0..2 give cosines, lanes 3..5 sines
  typedef struct packed {
    logic                  valid;
    lane_t [LANES-1:0]     lane;
  } cordic_t;

  function automatic logic signed [Z_W-1:0] atan_turn(input logic [IDX_W-1:0] i);
    logic [31:0] a;
    case (6'(i))
      6'd0:  a = 32'h20000000;
      6'd1:  a = 32'h12E4051E;
      6'd2:  a = 32'h09FB385B;
      6'd3:  a = 32'h051111D4;
      6'd4:  a = 32'h028B0D43;
      6'd5:  a = 32'h0145D7E1;
      6'd6:  a = 32'h00A2F61E;
      6'd7:  a = 32'h00517C55;
      6'd8:  a = 32'h0028BE53;
      6'd9:  a = 32'h00145F2F;
      6'd10: a = 32'h000A2F98;
      6'd11: a = 32'h000517CC;
      6'd12: a = 32'h00028BE6;
      6'd13: a = 32'h000145F3;
      6'd14: a = 32'h0000A2FA;
      6'd15: a = 32'h0000517D;
      6'd16: a = 32'h000028BE;
      6'd17: a = 32'h0000145F;
      6'd18: a = 32'h00000A30;
      6'd19: a = 32'h00000518;
      6'd20: a = 32'h0000028C;
      6'd21: a = 32'h00000146;
      6'd22: a = 32'h000000A3;
      6'd23: a = 32'h00000051;
      6'd24: a = 32'h00000029;
      6'd25: a = 32'h00000014;
      6'd26: a = 32'h0000000A;
      6'd27: a = 32'h00000005;
      6'd28: a = 32'h00000003;
      6'd29: a = 32'h00000001;
      6'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return $signed({1'b0, a});
  endfunction

endpackage

[src/nop_div_cell.sv]
// One restoring-division step for the three phase lanes.
// Depends on nop_pkg.
module nop_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [2:0]    coef_bit,
  input  nop_pkg::div_t din,
  output nop_pkg::div_t dout
);
  import nop_pkg::*;

  div_t nxt;

  always_comb begin
    logic [ENERGY_W:0] t;
    nxt = din;
    for (int k = 0; k < 3; k++) begin
      t = {din.rem[k], coef_bit[k]};
      if (t >= {1'b0, din.energy}) begin
        nxt.rem[k] = ENERGY_W'(t - {1'b0, din.energy});
        nxt.quo[k] = {din.quo[k][PHASE_W-2:0], 1'b1};
      end else begin
        nxt.rem[k] = t[ENERGY_W-1:0];
        nxt.quo[k] = {din.quo[k][PHASE_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= nxt;
    end
  end

endmodule

[src/nop_cordic_cell.sv]
// One rotation step of the six CORDIC lanes.
// Depends on nop_pkg.
module nop_cordic_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [nop_pkg::IDX_W-1:0]  idx,
  input  nop_pkg::cordic_t           din,
  output nop_pkg::cordic_t           dout
);
  import nop_pkg::*;

  cordic_t nxt;

  always_comb begin
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  a;
    nxt = din;
    a = atan_turn(idx);
    for (int k = 0; k < LANES; k++) begin
      dx = din.lane[k].y >>> idx;
      dy = din.lane[k].x >>> idx;
      if (!din.lane[k].z[Z_W-1]) begin
        nxt.lane[k].x = din.lane[k].x - dx;
        nxt.lane[k].y = din.lane[k].y + dy;
        nxt.lane[k].z = din.lane[k].z - a;
      end else begin
        nxt.lane[k].x = din.lane[k].x + dx;
        nxt.lane[k].y = din.lane[k].y - dy;
        nxt.lane[k].z = din.lane[k].z + a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= nxt;
    end
  end

endmodule

[src/nop_post.sv]
// Weighting, sine product, CP term and saturation after the CORDIC row.
// Depends on nop_pkg.
module nop_post (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  nop_pkg::cfg_t    cfg,
  input  nop_pkg::cordic_t din,
  output logic             out_valid,
  output logic [31:0]      out_prob
);
  import nop_pkg::*;

  logic [5:0] v;
  logic signed [31:0] c [3];
  logic signed [31:0] s [3];
  logic signed [63:0] wc [3];
  logic signed [63:0] sp01;
  logic signed [31:0] s2_d2;
  logic signed [31:0] s2_d3;
  logic signed [31:0] sp1;
  logic signed [ACC_W-1:0] tsum3, tsum4, tsum5;
  logic signed [63:0] sp2;
  logic signed [63:0] cpp;

  logic signed [ACC_W-1:0] tsum_next;
  logic signed [ACC_W-1:0] acc;
  logic signed [63:0] sp1_w;
  logic signed [63:0] sp2_sh;
  logic signed [63:0] cpp_sh;

  always_comb begin
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] wsum;
    tsum_next = '0;
    wsum = '0;
    for (int k = 0; k < 3; k++) begin
      t = ACC_W'(wc[k] >>> 30);
      tsum_next = tsum_next + t;
      wsum = wsum + ACC_W'($signed(cfg.weight[k]));
    end
    tsum_next = (tsum_next <<< 1) - (wsum <<< 1);
    if (!cfg.app) begin
      tsum_next = tsum_next + (ACC_W'(1) <<< 29);
    end
    sp1_w = sp01 >>> 30;
    sp2_sh = sp2 >>> 30;
    cpp_sh = cpp >>> 30;
    acc = tsum5;
    if (cfg.app) begin
      acc = acc + (ACC_W'(cpp_sh) <<< 3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[4:0], din.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: undo the fold and cut to Q.30
      for (int k = 0; k < 3; k++) begin
        c[k] <= 32'((din.lane[k].flip ? -din.lane[k].x : din.lane[k].x) >>> 2);
        s[k] <= 32'((din.lane[k+3].flip ? -din.lane[k+3].y : din.lane[k+3].y) >>> 2);
      end
      // stage 2: weight products and first sine product
      for (int k = 0; k < 3; k++) begin
        wc[k] <= $signed(cfg.weight[k]) * c[k];
      end
      sp01 <= s[0] * s[1];
      s2_d2 <= s[2];
      // stage 3: cosine sum
      tsum3 <= tsum_next;
      sp1 <= 32'(sp1_w);
      s2_d3 <= s2_d2;
      // stage 4: second sine product
      sp2 <= sp1 * s2_d3;
      tsum4 <= tsum3;
      // stage 5: CP weight
      cpp <= $signed(cfg.cp) * $signed(32'(sp2_sh));
      tsum5 <= tsum4;
      // stage 6: final sum, clamp
      if (acc > ACC_W'(64'sh7FFFFFFF)) begin
        out_prob <= 32'h7FFFFFFF;
      end else if (acc < -(ACC_W'(64'sh80000000))) begin
        out_prob <= 32'h80000000;
      end else begin
        out_prob <= acc[31:0];
      end
    end
  end

  assign out_valid = v[5];

endmodule

[src/neutrino_oscillation_probability.sv]
// Top level: three-flavour vacuum oscillation probability, one energy word per cycle.
// Depends on nop_pkg, nop_div_cell, nop_cordic_cell and nop_post.
//
// Usage
//   s_* stream carries energy words in, m_* stream carries probability words out.
//   Configuration goes through cfg_we / cfg_index / cfg_data, only while idle.
//   The word passes a row of 48 division cells (one quotient bit each, three
//   pairs side by side), a row of CORDIC_STAGES rotation cells (six lanes:
//   three cosines, three sines), then six post stages of products and sums.
//   From acceptance to m_tvalid a word passes the 48 division, CORDIC_STAGES
//   rotation and six post registers, then the output buffer.
//   Throughput: one word per cycle while the row is not frozen, set by the
//   cell rows each taking a new word every cycle in which they advance.
//   A two-entry output buffer decouples the receiver: while it holds two
//   words the whole row freezes and s_tready drops; with one word waiting
//   the row still accepts input.
//   Reset clears all configuration to zero, empties the row and the buffer.
module neutrino_oscillation_probability (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [23:0] energy
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] probability
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  import nop_pkg::*;

  cfg_t cfg;
  logic advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_COEF_12:   cfg.coef[0] <= cfg_data;
        REG_COEF_13:   cfg.coef[1] <= cfg_data;
        REG_COEF_23:   cfg.coef[2] <= cfg_data;
        REG_WEIGHT_12: cfg.weight[0] <= cfg_data[31:0];
        REG_WEIGHT_13: cfg.weight[1] <= cfg_data[31:0];
        REG_WEIGHT_23: cfg.weight[2] <= cfg_data[31:0];
        REG_CP_WEIGHT: cfg.cp <= cfg_data[31:0];
        REG_APPEAR:    cfg.app <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // division row: phase = coef / energy, low 33 quotient bits
  div_t div_pipe [DIV_STAGES+1];

  always_comb begin
    div_pipe[0] = '0;
    div_pipe[0].valid = s_tvalid;
    div_pipe[0].energy = s_tdata;
  end

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    nop_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (advance),
      .coef_bit({cfg.coef[2][DIV_STAGES-1-i], cfg.coef[1][DIV_STAGES-1-i],
                 cfg.coef[0][DIV_STAGES-1-i]}),
      .din     (div_pipe[i]),
      .dout    (div_pipe[i+1])
    );
  end

  // fold angles into a quarter turn ahead of the rotation row
  cordic_t cor_pipe [CORDIC_STAGES+1];

  always_comb begin
    logic [PHASE_W-1:0] p;
    logic [31:0] turn;
    logic signed [Z_W-1:0] z;
    cor_pipe[0].valid = div_pipe[DIV_STAGES].valid;
    for (int k = 0; k < LANES; k++) begin
      // zero energy gives zero phase
      p = (div_pipe[DIV_STAGES].energy == '0) ? '0 : div_pipe[DIV_STAGES].quo[k % 3];
      turn = (k < 3) ? p[31:0] : p[32:1];
      z = $signed({turn[31], turn});
      cor_pipe[0].lane[k].flip = 1'b0;
      if (z > $signed(33'sh040000000)) begin
        z = z - $signed(33'sh080000000);
        cor_pipe[0].lane[k].flip = 1'b1;
      end else if (z < -$signed(33'sh040000000)) begin
        z = z + $signed(33'sh080000000);
        cor_pipe[0].lane[k].flip = 1'b1;
      end
      cor_pipe[0].lane[k].z = z;
      cor_pipe[0].lane[k].x = $signed({4'b0, CORDIC_GAIN});
      cor_pipe[0].lane[k].y = '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    nop_cordic_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (advance),
      .idx (IDX_W'(i)),
      .din (cor_pipe[i]),
      .dout(cor_pipe[i+1])
    );
  end

  logic        post_valid;
  logic [31:0] post_prob;

  nop_post u_post (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .cfg      (cfg),
    .din      (cor_pipe[CORDIC_STAGES]),
    .out_valid(post_valid),
    .out_prob (post_prob)
  );

  // two-word output buffer
  logic [31:0] obuf [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;
  logic        push, pop;

  assign advance  = (count != 2'd2);
  assign s_tready = advance;
  assign push     = advance && post_valid;
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != 2'd0);
  assign m_tdata  = obuf[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      obuf[wr_ptr] <= post_prob;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[tb/sv/tb_neutrino_oscillation_probability.sv]
// Testbench for neutrino_oscillation_probability: streams energy words through
// the block and checks each probability word against a local predictor.
// Depends on nop_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_neutrino_oscillation_probability;
  import nop_pkg::*;

  localparam int NSTAGES = CORDIC_STAGES;
  localparam int LATENCY = 100;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // [23:0] energy
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [31:0] probability
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;

  neutrino_oscillation_probability uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor's copy of the registers
  logic [47:0]        coef_q[3];
  logic signed [31:0] weight_q[3];
  logic signed [31:0] cp_q;
  logic               appear_q;

  logic [23:0]        energy_queue[$];   // words waiting to be offered
  logic [31:0]        prob_queue[$];     // predicted probabilities

  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_cycles;      // receiver hold-off, counted down by the receiver
  int  mismatches;

  // handshake seen at the last rising edge, kept for the driver
  logic s_tready_seen;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("** neutrino_oscillation_probability: FAILED **");
    $finish;
  end

  // arctangent of 2^-i in 2^-32 turns
  function automatic longint arctan_turns(int i);
    longint t[32] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
      'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
      'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
      'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001,
      'h00000001, 'h00000000};
    return i < 32 ? t[i] : 0;
  endfunction

  // rotation CORDIC, angle in 2^-32 turns; cos and sin back in Q.30.
  // >>> on longint floors, as the hardware does.
  function automatic void rotate(input logic [31:0] turn, output longint cosv,
                                 output longint sinv);
    longint x, y, z, dx, dy;
    bit     flip;
    x = 64'sh9B74EDA8;
    y = 0;
    z = longint'($signed(turn));
    flip = 1'b0;
    if (z > 64'sh40000000) begin
      z -= 64'sh80000000;
      flip = 1'b1;
    end else if (z < -64'sh40000000) begin
      z += 64'sh80000000;
      flip = 1'b1;
    end
    for (int i = 0; i < NSTAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_turns(i);
      end else begin
        x += dx; y -= dy; z += arctan_turns(i);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cosv = x >>> 2;
    sinv = y >>> 2;
  endfunction

  function automatic logic [31:0] oscillation_prob(logic [23:0] energy);
    longint acc, sprod, c, s, unused, w;
    logic [32:0] ph;
    acc = appear_q ? 0 : (64'sd1 <<< 29);
    sprod = 0;
    for (int k = 0; k < 3; k++) begin
      ph = (energy == 0) ? '0 : 33'(64'(coef_q[k]) / 64'(energy));
      w = longint'(weight_q[k]);
      rotate(ph[31:0], c, unused);
      acc += 2 * ((w * c) >>> 30);
      acc -= 2 * w;
      rotate(ph[32:1], unused, s);
      sprod = (k == 0) ? s : ((sprod * s) >>> 30);
    end
    if (appear_q) acc += 8 * ((longint'(cp_q) * sprod) >>> 30);
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    else if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return acc[31:0];
  endfunction

  // driver: offers queued words, drops them once taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready_seen) void'(energy_queue.pop_front());
      if (energy_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= energy_queue[0];
      end else if (!(s_tvalid && !s_tready_seen)) begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    s_tready_seen <= s_tready;
    if (!rst && s_tvalid && s_tready)
      prob_queue.push_back(oscillation_prob(s_tdata));
  end

  // monitor: checks each probability word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (prob_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", m_tdata);
      end else begin
        if (m_tdata !== prob_queue[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("probability mismatch: expected %h, got %h",
                     prob_queue[0], m_tdata);
        end
        void'(prob_queue.pop_front());
      end
    end
  end

  // receiver ready, with a long hold-off when asked
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [47:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_COEF_12:   coef_q[0] = value;
      REG_COEF_13:   coef_q[1] = value;
      REG_COEF_23:   coef_q[2] = value;
      REG_WEIGHT_12: weight_q[0] = value[31:0];
      REG_WEIGHT_13: weight_q[1] = value[31:0];
      REG_WEIGHT_23: weight_q[2] = value[31:0];
      REG_CP_WEIGHT: cp_q = value[31:0];
      REG_APPEAR:    appear_q = value[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (energy_queue.size() > 0 || s_tvalid || prob_queue.size() > 0)
      @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_energy();
    case ($urandom_range(3))
      0: return 24'($urandom_range(1, 255));
      1: return 24'($urandom_range(1, 65535));
      default: return 24'($urandom_range(1, 24'hFFFFFF));
    endcase
  endfunction

  function automatic logic [47:0] rand_coef();
    return {16'($urandom), 32'($urandom)} >> $urandom_range(0, 24);
  endfunction

  // one setting: random or extreme register values, then a batch of words
  task automatic run_phase(int kind, int words);
    logic [31:0] w;
    for (int k = 0; k < 3; k++) begin
      case (kind)
        0: write_reg(reg_idx_t'(k), 48'hFFFF_FFFF_FFFF);
        1: write_reg(reg_idx_t'(k), 48'd0);
        default: write_reg(reg_idx_t'(k), rand_coef());
      endcase
    end
    for (int k = 0; k < 4; k++) begin
      case (kind)
        0: w = 32'h7FFF_FFFF;
        1: w = 32'h8000_0000;
        default: w = $urandom() >>> $urandom_range(0, 3);
      endcase
      write_reg(reg_idx_t'(k + 3), {16'd0, w});
    end
    write_reg(REG_APPEAR, 48'($urandom_range(1)));
    for (int n = 0; n < words; n++) energy_queue.push_back(rand_energy());
    drain();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_COEF_12;
    cfg_data = '0;
    hold_cycles = 0;
    mismatches = 0;
    send_idle_pct = 18;
    recv_idle_pct = 52;
    for (int k = 0; k < 3; k++) begin
      coef_q[k] = '0;
      weight_q[k] = '0;
    end
    cp_q = '0;
    appear_q = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset configuration, then extreme energies on mixed settings
    energy_queue.push_back(24'd1);
    energy_queue.push_back(24'hFFFFFF);
    drain();
    write_reg(REG_COEF_12, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_COEF_13, 48'h0000_8000_0000);
    write_reg(REG_COEF_23, 48'h0001_4000_0000);
    write_reg(REG_WEIGHT_12, 48'h2000_0000);
    write_reg(REG_WEIGHT_13, 48'h8000_0000);
    write_reg(REG_WEIGHT_23, 48'h7FFF_FFFF);
    write_reg(REG_CP_WEIGHT, 48'h7FFF_FFFF);
    for (int a = 0; a < 2; a++) begin
      write_reg(REG_APPEAR, 48'(a));
      energy_queue.push_back(24'd1);
      energy_queue.push_back(24'd2);
      energy_queue.push_back(24'd3);
      energy_queue.push_back(24'hFFFFFF);
      energy_queue.push_back(24'h800000);
      energy_queue.push_back(24'h000100);
      energy_queue.push_back(24'h555555);
      energy_queue.push_back(24'hAAAAAA);
      drain();
    end
    run_phase(0, 10);
    run_phase(1, 10);

    // long receiver stall while the sender keeps offering
    for (int n = 0; n < 150; n++) energy_queue.push_back(rand_energy());
    hold_cycles = 300;
    drain();

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 18 : (p == 1) ? 52 : 0;
      recv_idle_pct = (p == 0) ? 52 : (p == 1) ? 18 : 0;
      for (int q = 0; q < 4; q++) run_phase(2, 70);
    end

    if (mismatches == 0)
      $display("** neutrino_oscillation_probability: PASSED **");
    else
      $display("** neutrino_oscillation_probability: FAILED **");
    $finish;
  end

endmodule
